// ===== hdl/bit_vector_last_one_query_core_macros.svh =====
// ----------------------------------------------------------------------------
// bit_vector_last_one_query_core_macros.svh
// Assertion macros shared by the bit vector last-one query core.
// ----------------------------------------------------------------------------
`ifndef BIT_VECTOR_LAST_ONE_QUERY_CORE_MACROS_SVH
`define BIT_VECTOR_LAST_ONE_QUERY_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define BVLQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bvlq: implication check failed");

// next-cycle implication, clocked on clk, off during reset
`define BVLQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bvlq: next-cycle check failed");

`endif

// ===== hdl/bvlq_pkg.sv =====
// ----------------------------------------------------------------------------
// bvlq_pkg
// Types, constants and helpers for the bit vector last-one query core.
// ----------------------------------------------------------------------------
package bvlq_pkg;

	localparam int unsigned MAX_BITS   = 4096;
	localparam int unsigned BLOCK_BITS = 16;
	localparam int unsigned NUM_BLOCKS = MAX_BITS / BLOCK_BITS;
	localparam int unsigned POS_W      = 13;
	localparam int unsigned OFF_W      = $clog2(BLOCK_BITS);
	localparam int unsigned BLK_W      = $clog2(NUM_BLOCKS);
	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned STAT_W     = 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_SET    = 2'd1,
		FUNC_QUERY  = 2'd2
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_BOUND = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef logic [BLOCK_BITS-1:0] word_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [BLK_W-1:0]      blk_t;
	typedef logic [OFF_W-1:0]      off_t;

	typedef struct packed {
		logic re;
		blk_t word_addr;
		blk_t last_addr;
	} rd_req_t;

	typedef struct packed {
		logic  we_word;
		logic  we_last;
		blk_t  addr;
		word_t word;
		pos_t  last;
	} wr_req_t;

	typedef struct packed {
		logic hit;
		off_t idx;
	} top_t;

	// highest set bit of a block word
	function automatic top_t top_bit(word_t w);
		top_t r;
		r = '0;
		for (int k = 0; k < BLOCK_BITS; k++) begin
			if (w[k]) begin
				r.hit = 1'b1;
				r.idx = off_t'(k);
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/bvlq_store.sv =====
// ----------------------------------------------------------------------------
// bvlq_store
// Block word and per-block summary memories, one registered read each.
// ----------------------------------------------------------------------------
module bvlq_store (
	input  logic              clk,
	input  bvlq_pkg::rd_req_t rd,
	input  bvlq_pkg::wr_req_t wr,
	output bvlq_pkg::word_t   rd_word,
	output bvlq_pkg::pos_t    rd_last
);

	bvlq_pkg::word_t words_q [bvlq_pkg::NUM_BLOCKS];
	bvlq_pkg::pos_t  lasts_q [bvlq_pkg::NUM_BLOCKS];
	bvlq_pkg::word_t rd_word_q;
	bvlq_pkg::pos_t  rd_last_q;

	always_ff @(posedge clk) begin
		if (wr.we_word) begin
			words_q[wr.addr] <= wr.word;
		end
		if (rd.re) begin
			rd_word_q <= words_q[rd.word_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we_last) begin
			lasts_q[wr.addr] <= wr.last;
		end
		if (rd.re) begin
			rd_last_q <= lasts_q[rd.last_addr];
		end
	end

	assign rd_word = rd_word_q;
	assign rd_last = rd_last_q;

endmodule

// ===== hdl/bit_vector_last_one_query_core.sv =====
// ----------------------------------------------------------------------------
// bit_vector_last_one_query_core
// Growing bit string in 16-bit block words with a per-block summary of the
// last one; append, overwrite-last and last-one-at-or-before queries.
//
//   channel  words                               flow control
//   in       func, bit_value, query_pos          in_valid / in_stall
//   out      last_one_pos, found, status         out_valid / out_stall
//
// The accept edge issues the memory reads; the edge that ends the execute
// step does the search, writes back and loads the output register.
// The input is held off during the execute step, so a read never overlaps
// the write-back of the word before it; this interlock sets the rate.
// After reset the string is empty; memories need no clearing.
// A new word is taken while a result waits in the output register; a
// stalled output holds the core in its execute step.
// ----------------------------------------------------------------------------
`include "bit_vector_last_one_query_core_macros.svh"

module bit_vector_last_one_query_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bvlq_pkg::FUNC_W-1:0]    func,
	input  logic                           bit_value,
	input  logic [bvlq_pkg::POS_W-1:0]     query_pos,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bvlq_pkg::POS_W-1:0]     last_one_pos,
	output logic                           found,
	output logic [bvlq_pkg::STAT_W-1:0]    status
);

	localparam int unsigned IDX_W = bvlq_pkg::BLK_W + bvlq_pkg::OFF_W;

	bvlq_pkg::state_t  state_q, state_d;
	bvlq_pkg::pos_t    bit_count_q;
	bvlq_pkg::rd_req_t rd;
	bvlq_pkg::wr_req_t wr;
	bvlq_pkg::word_t   rd_word;
	bvlq_pkg::pos_t    rd_last;

	logic accept_in;
	logic fire;

	// accept-time decode
	bvlq_pkg::pos_t              idx;
	logic                        act;
	logic [bvlq_pkg::STAT_W-1:0] stat;
	bvlq_pkg::blk_t              blk;
	bvlq_pkg::off_t              off;

	logic [bvlq_pkg::FUNC_W-1:0] func_s1;
	logic                        bit_s1;
	bvlq_pkg::blk_t              blk_s1;
	bvlq_pkg::off_t              off_s1;
	logic [bvlq_pkg::STAT_W-1:0] stat_s1;
	logic                        act_s1;

	// execute step
	bvlq_pkg::pos_t  prev_last;
	bvlq_pkg::word_t new_word;
	bvlq_pkg::word_t q_mask;
	bvlq_pkg::top_t  full_top;
	bvlq_pkg::top_t  q_top;
	bvlq_pkg::pos_t  summary;
	bvlq_pkg::pos_t  q_pos;
	logic            is_write;

	logic                        out_valid_q;
	bvlq_pkg::pos_t              last_one_pos_q;
	logic                        found_q;
	logic [bvlq_pkg::STAT_W-1:0] status_q;

	always_comb begin
		idx  = '0;
		act  = 1'b0;
		stat = bvlq_pkg::ST_OK;
		case (func)
			bvlq_pkg::FUNC_APPEND: begin
				idx = bit_count_q;
				if (bit_count_q >= bvlq_pkg::pos_t'(bvlq_pkg::MAX_BITS)) begin
					stat = bvlq_pkg::ST_BOUND;
				end else begin
					act = 1'b1;
				end
			end
			bvlq_pkg::FUNC_SET: begin
				idx = bit_count_q - bvlq_pkg::pos_t'(1);
				if (bit_count_q == '0) begin
					stat = bvlq_pkg::ST_BOUND;
				end else begin
					act = 1'b1;
				end
			end
			bvlq_pkg::FUNC_QUERY: begin
				idx = query_pos - bvlq_pkg::pos_t'(1);
				if (query_pos > bit_count_q) begin
					stat = bvlq_pkg::ST_RANGE;
				end else begin
					act = (query_pos != '0);
				end
			end
			default: begin
				idx = '0;
			end
		endcase
		blk = idx[IDX_W-1:bvlq_pkg::OFF_W];
		off = idx[bvlq_pkg::OFF_W-1:0];
	end

	assign accept_in = in_valid && !in_stall;
	assign fire      = (state_q == bvlq_pkg::S_EXEC) && (!out_valid_q || !out_stall);

	always_comb begin
		rd.re        = accept_in;
		rd.word_addr = blk;
		rd.last_addr = blk - bvlq_pkg::blk_t'(1);
	end

	bvlq_store u_store (
		.clk     (clk),
		.rd      (rd),
		.wr      (wr),
		.rd_word (rd_word),
		.rd_last (rd_last)
	);

	always_ff @(posedge clk) begin
		if (accept_in) begin
			func_s1 <= func;
			bit_s1  <= bit_value;
			blk_s1  <= blk;
			off_s1  <= off;
			stat_s1 <= stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else if (accept_in) begin
			act_s1 <= act;
		end
	end

	always_comb begin
		prev_last = (blk_s1 == '0) ? '0 : rd_last;
		case (func_s1)
			bvlq_pkg::FUNC_APPEND: begin
				if (off_s1 == '0) begin
					new_word = bvlq_pkg::word_t'(bit_s1);
				end else begin
					new_word = rd_word | (bvlq_pkg::word_t'(bit_s1) << off_s1);
				end
			end
			bvlq_pkg::FUNC_SET: begin
				new_word = (rd_word & ~(bvlq_pkg::word_t'(1) << off_s1))
					| (bvlq_pkg::word_t'(bit_s1) << off_s1);
			end
			default: begin
				new_word = rd_word;
			end
		endcase
		full_top = bvlq_pkg::top_bit(new_word);
		summary  = full_top.hit
			? bvlq_pkg::pos_t'({blk_s1, full_top.idx}) + bvlq_pkg::pos_t'(1)
			: prev_last;

		q_mask = {bvlq_pkg::BLOCK_BITS{1'b1}}
			>> (bvlq_pkg::off_t'(bvlq_pkg::BLOCK_BITS - 1) - off_s1);
		q_top  = bvlq_pkg::top_bit(rd_word & q_mask);
		q_pos  = q_top.hit
			? bvlq_pkg::pos_t'({blk_s1, q_top.idx}) + bvlq_pkg::pos_t'(1)
			: prev_last;

		is_write = (func_s1 == bvlq_pkg::FUNC_APPEND) || (func_s1 == bvlq_pkg::FUNC_SET);
	end

	always_comb begin
		wr.we_word = fire && act_s1 && is_write;
		wr.we_last = fire && act_s1 && is_write && (off_s1 == '1);
		wr.addr    = blk_s1;
		wr.word    = new_word;
		wr.last    = summary;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= '0;
		end else if (fire && act_s1 && (func_s1 == bvlq_pkg::FUNC_APPEND)) begin
			bit_count_q <= bit_count_q + bvlq_pkg::pos_t'(1);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvlq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bvlq_pkg::S_IDLE: begin
				if (accept_in) begin
					state_d = bvlq_pkg::S_EXEC;
				end
			end
			bvlq_pkg::S_EXEC: begin
				if (fire) begin
					state_d = bvlq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bvlq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			bvlq_pkg::S_IDLE: begin
				in_stall = 1'b0;
			end
			bvlq_pkg::S_EXEC: begin
				in_stall = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= stat_s1;
			if (act_s1 && (func_s1 == bvlq_pkg::FUNC_QUERY)) begin
				last_one_pos_q <= q_pos;
				found_q        <= (q_pos != '0);
			end else begin
				last_one_pos_q <= '0;
				found_q        <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign last_one_pos = last_one_pos_q;
	assign found        = found_q;
	assign status       = status_q;

	`BVLQ_ASSERT_IMP(a_found_matches_pos, out_valid, found == (last_one_pos != '0))
	`BVLQ_ASSERT_IMP(a_error_no_result, out_valid && (status != bvlq_pkg::ST_OK), last_one_pos == '0)
	`BVLQ_ASSERT_NXT(a_accept_to_exec, accept_in, state_q == bvlq_pkg::S_EXEC)
	`BVLQ_ASSERT_IMP(a_count_bound, 1'b1, bit_count_q <= bvlq_pkg::pos_t'(bvlq_pkg::MAX_BITS))
	`BVLQ_ASSERT_IMP(a_write_in_exec, wr.we_word || wr.we_last, state_q == bvlq_pkg::S_EXEC)

endmodule

// ===== dv/bvlq_answer_checker.sv =====
// ----------------------------------------------------------------------------
// bvlq_answer_checker
// Watches both channels of the bit vector last-one query core, keeps its own
// copy of the bit string and block summaries, predicts the answer word for
// every accepted input word and compares it field by field.
// ----------------------------------------------------------------------------
module bvlq_answer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [bvlq_pkg::FUNC_W-1:0]    func,
	input  logic                           bit_value,
	input  logic [bvlq_pkg::POS_W-1:0]     query_pos,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [bvlq_pkg::POS_W-1:0]     last_one_pos,
	input  logic                           found,
	input  logic [bvlq_pkg::STAT_W-1:0]    status,
	output int                             fail_count,
	output int                             pending
);

	typedef struct packed {
		bvlq_pkg::pos_t    pos;
		logic              fnd;
		bvlq_pkg::status_t st;
	} answer_t;

	bvlq_pkg::word_t blk_word [bvlq_pkg::NUM_BLOCKS];
	bvlq_pkg::pos_t  blk_tail [bvlq_pkg::NUM_BLOCKS];
	int unsigned     length;
	int unsigned     n_answers;
	answer_t         answer_q [$];
	answer_t         want;

	// 1-based index of the highest one among the low lim bits, 0 if none
	function automatic int unsigned highest_one(bvlq_pkg::word_t w, int unsigned lim);
		for (int k = lim; k > 0; k--) begin
			if (w[k-1])
				return k;
		end
		return 0;
	endfunction

	// last one up to the end of a completed block
	function automatic bvlq_pkg::pos_t tail_of(int unsigned blk);
		int unsigned t;
		t = highest_one(blk_word[blk], bvlq_pkg::BLOCK_BITS);
		if (t > 0)
			return bvlq_pkg::pos_t'(blk * bvlq_pkg::BLOCK_BITS + t);
		if (blk > 0)
			return blk_tail[blk-1];
		return '0;
	endfunction

	function automatic answer_t predict_answer(logic [bvlq_pkg::FUNC_W-1:0] f, logic b,
		bvlq_pkg::pos_t q);
		answer_t     a;
		int unsigned blk;
		int unsigned off;
		int unsigned t;
		a = '0;
		a.st = bvlq_pkg::ST_OK;
		case (f)
			bvlq_pkg::FUNC_APPEND: begin
				if (length >= bvlq_pkg::MAX_BITS) begin
					a.st = bvlq_pkg::ST_BOUND;
				end else begin
					blk = length / bvlq_pkg::BLOCK_BITS;
					off = length % bvlq_pkg::BLOCK_BITS;
					if (off == 0)
						blk_word[blk] = '0;
					blk_word[blk][off] = b;
					length++;
					if (off == bvlq_pkg::BLOCK_BITS - 1)
						blk_tail[blk] = tail_of(blk);
				end
			end
			bvlq_pkg::FUNC_SET: begin
				if (length == 0) begin
					a.st = bvlq_pkg::ST_BOUND;
				end else begin
					blk = (length - 1) / bvlq_pkg::BLOCK_BITS;
					off = (length - 1) % bvlq_pkg::BLOCK_BITS;
					blk_word[blk][off] = b;
					if (off == bvlq_pkg::BLOCK_BITS - 1)
						blk_tail[blk] = tail_of(blk);
				end
			end
			bvlq_pkg::FUNC_QUERY: begin
				if (q > length) begin
					a.st = bvlq_pkg::ST_RANGE;
				end else if (q > 0) begin
					blk = (q - 1) / bvlq_pkg::BLOCK_BITS;
					t = highest_one(blk_word[blk], q - blk * bvlq_pkg::BLOCK_BITS);
					if (t > 0)
						a.pos = bvlq_pkg::pos_t'(blk * bvlq_pkg::BLOCK_BITS + t);
					else if (blk > 0)
						a.pos = blk_tail[blk-1];
					a.fnd = (a.pos != '0);
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic report_mismatch(string what, int got, int exp_val);
		$display("mismatch on answer %0d: %s got %0d, want %0d", n_answers, what, got,
			exp_val);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length = 0;
			n_answers = 0;
			answer_q.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			// an answer leaving at this edge always belongs to an earlier word
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					report_mismatch("unexpected word, last_one_pos", int'(last_one_pos), 0);
				end else begin
					want = answer_q.pop_front();
					if (last_one_pos !== want.pos)
						report_mismatch("last_one_pos", int'(last_one_pos), int'(want.pos));
					if (found !== want.fnd)
						report_mismatch("found", int'(found), int'(want.fnd));
					if (status !== want.st)
						report_mismatch("status", int'(status), int'(want.st));
				end
				n_answers++;
			end
			if (in_valid && !in_stall)
				answer_q.insert(answer_q.size(), predict_answer(func, bit_value, query_pos));
			pending = answer_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bit vector last-one query core: directed corner words on
// an empty string and around the first block, then a random mix of appends,
// overwrites, queries and spare function codes, with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module tb_top;

	typedef enum int {
		STALL_OFF,
		STALL_COIN,
		STALL_HEAVY
	} stall_mode_t;

	localparam logic [bvlq_pkg::FUNC_W-1:0] FUNC_SPARE   = 2'd3;
	localparam int                          RANDOM_WORDS = 1024;
	localparam int                          RUN_LIMIT    = 1000000;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic [bvlq_pkg::FUNC_W-1:0]   func      = bvlq_pkg::FUNC_APPEND;
	logic                          bit_value = 1'b0;
	bvlq_pkg::pos_t                query_pos = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	bvlq_pkg::pos_t                last_one_pos;
	logic                          found;
	logic [bvlq_pkg::STAT_W-1:0]   status;

	int                  fail_count;
	int                  pending;
	int                  cycles     = 0;
	int                  burst_left = 0;
	int unsigned         stored     = 0;
	int unsigned         ones_every = 2;
	stall_mode_t         stall_mode = STALL_OFF;
	int                  stall_left = 0;

	bit_vector_last_one_query_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.bit_value    (bit_value),
		.query_pos    (query_pos),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.last_one_pos (last_one_pos),
		.found        (found),
		.status       (status)
	);

	bvlq_answer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.bit_value    (bit_value),
		.query_pos    (query_pos),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.last_one_pos (last_one_pos),
		.found        (found),
		.status       (status),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		case (stall_mode)
			STALL_OFF:  out_stall <= 1'b0;
			STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
			default:    out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(logic [bvlq_pkg::FUNC_W-1:0] f, logic b, bvlq_pkg::pos_t q);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 24);
		end
		burst_left--;
		in_valid  <= 1'b1;
		func      <= f;
		bit_value <= b;
		query_pos <= q;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (f == bvlq_pkg::FUNC_APPEND && stored < bvlq_pkg::MAX_BITS)
			stored++;
	endtask

	function automatic logic pick_bit();
		return ($urandom_range(1, ones_every) == 1);
	endfunction

	function automatic bvlq_pkg::pos_t any_pos();
		return bvlq_pkg::pos_t'($urandom_range(0, bvlq_pkg::MAX_BITS));
	endfunction

	function automatic bvlq_pkg::pos_t pick_query();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0 || stored == 0)
			return any_pos();
		if (r == 1)
			return '0;
		if (r == 2)
			return bvlq_pkg::pos_t'(stored);
		if (r == 3 && stored < bvlq_pkg::MAX_BITS)
			return bvlq_pkg::pos_t'(stored + 1);
		return bvlq_pkg::pos_t'($urandom_range(1, stored));
	endfunction

	task automatic random_word(int unsigned pct_append);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (stored > 0 && stored % bvlq_pkg::BLOCK_BITS == 0 && $urandom_range(0, 5) == 0)
			send_word(bvlq_pkg::FUNC_SET, pick_bit(), any_pos());
		else if (r < pct_append)
			send_word(bvlq_pkg::FUNC_APPEND, pick_bit(), any_pos());
		else if (r < pct_append + 12)
			send_word(bvlq_pkg::FUNC_SET, pick_bit(), any_pos());
		else if (r < 97)
			send_word(bvlq_pkg::FUNC_QUERY, 1'($urandom_range(0, 1)), pick_query());
		else
			send_word(FUNC_SPARE, 1'($urandom_range(0, 1)), any_pos());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty string corners
		send_word(bvlq_pkg::FUNC_SET, 1'b1, '0);
		send_word(bvlq_pkg::FUNC_QUERY, 1'b0, '0);
		send_word(bvlq_pkg::FUNC_QUERY, 1'b1, bvlq_pkg::pos_t'(bvlq_pkg::MAX_BITS));
		send_word(FUNC_SPARE, 1'b1, bvlq_pkg::pos_t'(bvlq_pkg::MAX_BITS));
		// first block: single one at its last bit, then emptied and restored
		repeat (bvlq_pkg::BLOCK_BITS - 1) send_word(bvlq_pkg::FUNC_APPEND, 1'b0, '0);
		send_word(bvlq_pkg::FUNC_APPEND, 1'b1, bvlq_pkg::pos_t'(bvlq_pkg::BLOCK_BITS));
		send_word(bvlq_pkg::FUNC_SET, 1'b0, '0);
		send_word(bvlq_pkg::FUNC_QUERY, 1'b0, bvlq_pkg::pos_t'(bvlq_pkg::BLOCK_BITS));
		send_word(bvlq_pkg::FUNC_SET, 1'b1, '0);
		send_word(bvlq_pkg::FUNC_QUERY, 1'b0, bvlq_pkg::pos_t'(bvlq_pkg::BLOCK_BITS));
		send_word(bvlq_pkg::FUNC_QUERY, 1'b0, bvlq_pkg::pos_t'(bvlq_pkg::BLOCK_BITS - 1));
		send_word(bvlq_pkg::FUNC_QUERY, 1'b0, bvlq_pkg::pos_t'(bvlq_pkg::BLOCK_BITS + 1));

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 32 == 0)
				ones_every = (i % 64 == 0) ? $urandom_range(1, 3) : (1 << $urandom_range(2, 6));
			if (i == RANDOM_WORDS / 2) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
			end
			random_word(45);
		end

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bvlq_pkg.sv
hdl/bvlq_store.sv
hdl/bit_vector_last_one_query_core.sv
dv/bvlq_answer_checker.sv
dv/tb_top.sv
